// ===== hw/rtl/kmeans_cluster_engine_unit_macros.svh =====
// assertion macros for the k-means cluster engine
`ifndef KMEANS_CLUSTER_ENGINE_UNIT_MACROS_SVH
`define KMEANS_CLUSTER_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define KCE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KCE_ASSERT_SAME(lbl, ante, cons, msg)
`define KCE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/kce_pkg.sv =====
// shared constants and types of the k-means cluster engine
`default_nettype none
package kce_pkg;
    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 10;
    localparam int FEAT_BITS    = 16;
    localparam int NFEAT        = 5;
    localparam int PT_AW        = $clog2(MAX_POINTS);
    localparam int CNT_W        = PT_AW + 1;
    localparam int CL_W         = 4;
    localparam int SUM_W        = FEAT_BITS + PT_AW;
    localparam int ERR_W        = 48;
    localparam int PT_W         = FEAT_BITS * NFEAT;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_CENT = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    localparam logic [1:0] CFG_K     = 2'd0;
    localparam logic [1:0] CFG_MAXIT = 2'd1;
    localparam logic [1:0] CFG_DELTA = 2'd2;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/kmeans_cluster_engine_unit.sv =====
// top level of the k-means cluster engine
//
// channel   | handshake         | payload
// ----------+-------------------+---------------------------------------------
// command   | start, busy       | mode, slot, five features
// config    | wr_en             | wr_index, wr_data
// result    | result_valid      | cluster_index, means, member_count, errors
//
// load and centroid transactions are taken while idle; busy stays low
// a run repeats passes over the points, paced by the shared square unit and
// the serial divider, then gives k results
// results come back to back, one strobe each; the receiver cannot stall
// reset clears control state and centroids; the point memory needs no clearing
`default_nettype none
`include "kmeans_cluster_engine_unit_macros.svh"
module kmeans_cluster_engine_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    mode,
    input  wire logic [3:0]                    slot,
    input  wire logic [kce_pkg::FEAT_BITS-1:0] two_points,
    input  wire logic [kce_pkg::FEAT_BITS-1:0] three_points,
    input  wire logic [kce_pkg::FEAT_BITS-1:0] assists,
    input  wire logic [kce_pkg::FEAT_BITS-1:0] blocks,
    input  wire logic [kce_pkg::FEAT_BITS-1:0] fouls,
    input  wire logic                          wr_en,
    input  wire logic [1:0]                    wr_index,
    input  wire logic [kce_pkg::ERR_W-1:0]     wr_data,
    output logic                               result_valid,
    output logic [3:0]                         cluster_index,
    output logic [15:0]                        mean_two_points,
    output logic [15:0]                        mean_three_points,
    output logic [15:0]                        mean_assists,
    output logic [15:0]                        mean_blocks,
    output logic [15:0]                        mean_fouls,
    output logic [10:0]                        member_count,
    output logic [47:0]                        total_error,
    output logic [15:0]                        passes_run,
    output logic                               last
);
    import kce_pkg::*;

    localparam int DIST_W = 2 * FEAT_BITS + 3;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PASS   = 4'd1;
    localparam logic [3:0] S_A_RD   = 4'd2;
    localparam logic [3:0] S_A_DIST = 4'd3;
    localparam logic [3:0] S_A_UPD  = 4'd4;
    localparam logic [3:0] S_B_SEL  = 4'd5;
    localparam logic [3:0] S_B_DIV  = 4'd6;
    localparam logic [3:0] S_C_RD   = 4'd7;
    localparam logic [3:0] S_C_DIST = 4'd8;
    localparam logic [3:0] S_CHECK  = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0]           state_reg;
    logic [3:0]           k_cfg_reg;
    logic [15:0]          maxit_reg;
    logic [ERR_W-1:0]     delta_reg;
    logic [CNT_W-1:0]     pcount_reg;
    logic [NFEAT-1:0][FEAT_BITS-1:0] cen_reg [MAX_CLUSTERS];
    logic [NFEAT-1:0][SUM_W-1:0]     sum_reg [MAX_CLUSTERS];
    logic [CNT_W-1:0]     cnt_reg [MAX_CLUSTERS];
    logic [CL_W-1:0]      k_reg;
    logic [PT_AW-1:0]     i_reg;
    logic [CL_W-1:0]      j_reg;
    logic [2:0]           f_reg;
    logic [CL_W-1:0]      best_j_reg;
    logic [DIST_W-1:0]    best_d_reg;
    logic [DIST_W-1:0]    acc_reg;
    logic [2*FEAT_BITS-1:0] sq_reg;
    logic [ERR_W-1:0]     err_acc_reg;
    logic [ERR_W-1:0]     err_cur_reg;
    logic [15:0]          pass_reg;
    logic                 div_wait_reg;

    logic [PT_W-1:0]      pt_rdata;
    logic [CL_W-1:0]      lbl_rdata;
    logic                 pt_we;
    logic                 lbl_we;
    logic                 accept;
    logic [CL_W-1:0]      k_eff;
    logic [CL_W-1:0]      csel;
    logic [2:0]           fsel;
    logic [FEAT_BITS-1:0] pf;
    logic [FEAT_BITS-1:0] cf;
    logic [FEAT_BITS-1:0] diff;
    logic [DIST_W-1:0]    dist_sum;
    logic                 last_pt;
    logic [15:0]          pass_next;
    logic [ERR_W-1:0]     err_prev;
    logic [ERR_W-1:0]     err_diff;
    logic                 go_on;
    div_req_t             dreq;
    div_rsp_t             drsp;

    assign accept  = start && !busy;
    assign busy    = state_reg != S_IDLE;
    assign pt_we   = accept && mode == MODE_LOAD && pcount_reg < CNT_W'(MAX_POINTS);
    assign lbl_we  = state_reg == S_A_UPD;
    assign last_pt = {1'b0, i_reg} == pcount_reg - CNT_W'(1);

    always_comb
    begin
        if (k_cfg_reg == '0)
        begin
            k_eff = CL_W'(1);
        end
        else if (k_cfg_reg > CL_W'(MAX_CLUSTERS))
        begin
            k_eff = CL_W'(MAX_CLUSTERS);
        end
        else
        begin
            k_eff = k_cfg_reg;
        end
    end

    always_comb
    begin
        csel = j_reg;
        if (state_reg == S_C_DIST)
        begin
            csel = (lbl_rdata >= k_reg) ? '0 : lbl_rdata;
        end
        fsel     = (f_reg < 3'(NFEAT)) ? f_reg : 3'd0;
        pf       = pt_rdata[FEAT_BITS*fsel +: FEAT_BITS];
        cf       = cen_reg[csel][fsel];
        diff     = (pf > cf) ? (pf - cf) : (cf - pf);
        dist_sum = acc_reg + DIST_W'(sq_reg);
    end

    always_comb
    begin
        pass_next = pass_reg + 16'd1;
        err_prev  = (pass_reg == 16'd0) ? '0 : err_cur_reg;
        err_diff  = (err_prev > err_acc_reg) ? (err_prev - err_acc_reg)
                                             : (err_acc_reg - err_prev);
        go_on     = ({1'b0, pass_next} + 17'd1 < {1'b0, maxit_reg}) && err_diff > delta_reg;
    end

    always_comb
    begin
        dreq.start    = state_reg == S_B_SEL && j_reg < k_reg && cnt_reg[j_reg] != '0;
        dreq.dividend = sum_reg[j_reg < k_reg ? j_reg : '0][fsel];
        dreq.divisor  = cnt_reg[j_reg < k_reg ? j_reg : '0];
    end

    kce_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pcount_reg[PT_AW-1:0]),
        .wdata ({fouls, blocks, assists, three_points, two_points}),
        .raddr (i_reg),
        .rdata (pt_rdata)
    );

    kce_ram #(.WIDTH(CL_W), .DEPTH(MAX_POINTS)) u_label_ram (
        .clk   (clk),
        .we    (lbl_we),
        .waddr (i_reg),
        .wdata (best_j_reg),
        .raddr (i_reg),
        .rdata (lbl_rdata)
    );

    kce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            k_cfg_reg         <= 4'd3;
            maxit_reg         <= 16'd100;
            delta_reg         <= '0;
            pcount_reg        <= '0;
            k_reg             <= '0;
            i_reg             <= '0;
            j_reg             <= '0;
            f_reg             <= '0;
            best_j_reg        <= '0;
            best_d_reg        <= '0;
            acc_reg           <= '0;
            sq_reg            <= '0;
            err_acc_reg       <= '0;
            err_cur_reg       <= '0;
            pass_reg          <= '0;
            div_wait_reg      <= 1'b0;
            result_valid      <= 1'b0;
            last              <= 1'b0;
            cluster_index     <= '0;
            mean_two_points   <= '0;
            mean_three_points <= '0;
            mean_assists      <= '0;
            mean_blocks       <= '0;
            mean_fouls        <= '0;
            member_count      <= '0;
            total_error       <= '0;
            passes_run        <= '0;
            for (int c = 0; c < MAX_CLUSTERS; c++)
            begin
                cnt_reg[c] <= '0;
                for (int f = 0; f < NFEAT; f++)
                begin
                    cen_reg[c][f] <= '0;
                    sum_reg[c][f] <= '0;
                end
            end
        end
        else
        begin
            result_valid <= 1'b0;
            last         <= 1'b0;
            if (wr_en)
            begin
                case (wr_index)
                    CFG_K:     k_cfg_reg <= wr_data[3:0];
                    CFG_MAXIT: maxit_reg <= wr_data[15:0];
                    CFG_DELTA: delta_reg <= wr_data;
                    default:   ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (mode)
                            MODE_LOAD:
                            begin
                                if (pt_we)
                                begin
                                    pcount_reg <= pcount_reg + CNT_W'(1);
                                end
                            end
                            MODE_CENT:
                            begin
                                if (slot < 4'(MAX_CLUSTERS))
                                begin
                                    cen_reg[slot][0] <= two_points;
                                    cen_reg[slot][1] <= three_points;
                                    cen_reg[slot][2] <= assists;
                                    cen_reg[slot][3] <= blocks;
                                    cen_reg[slot][4] <= fouls;
                                end
                            end
                            MODE_RUN:
                            begin
                                k_reg     <= k_eff;
                                pass_reg  <= '0;
                                state_reg <= S_PASS;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PASS:
                begin
                    for (int c = 0; c < MAX_CLUSTERS; c++)
                    begin
                        cnt_reg[c] <= '0;
                        for (int f = 0; f < NFEAT; f++)
                        begin
                            sum_reg[c][f] <= '0;
                        end
                    end
                    i_reg       <= '0;
                    j_reg       <= '0;
                    f_reg       <= '0;
                    err_acc_reg <= '0;
                    state_reg   <= (pcount_reg == '0) ? S_B_SEL : S_A_RD;
                end
                S_A_RD, S_C_RD:
                begin
                    f_reg     <= '0;
                    state_reg <= (state_reg == S_A_RD) ? S_A_DIST : S_C_DIST;
                end
                S_A_DIST, S_C_DIST:
                begin
                    if (f_reg < 3'(NFEAT))
                    begin
                        sq_reg  <= diff * diff;
                        acc_reg <= (f_reg == 3'd0) ? '0 : dist_sum;
                        f_reg   <= f_reg + 3'd1;
                    end
                    else if (state_reg == S_A_DIST)
                    begin
                        if (j_reg == '0 || best_d_reg > dist_sum)
                        begin
                            best_d_reg <= dist_sum;
                            best_j_reg <= j_reg;
                        end
                        f_reg <= '0;
                        if (j_reg == k_reg - CL_W'(1))
                        begin
                            state_reg <= S_A_UPD;
                        end
                        else
                        begin
                            j_reg <= j_reg + CL_W'(1);
                        end
                    end
                    else
                    begin
                        err_acc_reg <= err_acc_reg + ERR_W'(dist_sum);
                        if (last_pt)
                        begin
                            state_reg <= S_CHECK;
                        end
                        else
                        begin
                            i_reg     <= i_reg + PT_AW'(1);
                            state_reg <= S_C_RD;
                        end
                    end
                end
                S_A_UPD:
                begin
                    cnt_reg[best_j_reg] <= cnt_reg[best_j_reg] + CNT_W'(1);
                    for (int f = 0; f < NFEAT; f++)
                    begin
                        sum_reg[best_j_reg][f] <= sum_reg[best_j_reg][f]
                            + SUM_W'(pt_rdata[FEAT_BITS*f +: FEAT_BITS]);
                    end
                    j_reg <= '0;
                    if (last_pt)
                    begin
                        i_reg     <= '0;
                        f_reg     <= '0;
                        state_reg <= S_B_SEL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + PT_AW'(1);
                        state_reg <= S_A_RD;
                    end
                end
                S_B_SEL:
                begin
                    if (j_reg >= k_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= (pcount_reg == '0) ? S_CHECK : S_C_RD;
                    end
                    else if (cnt_reg[j_reg] == '0)
                    begin
                        j_reg <= j_reg + CL_W'(1);
                    end
                    else
                    begin
                        div_wait_reg <= 1'b1;
                        state_reg    <= S_B_DIV;
                    end
                end
                S_B_DIV:
                begin
                    if (drsp.done)
                    begin
                        div_wait_reg         <= 1'b0;
                        cen_reg[j_reg][fsel] <= drsp.quotient[FEAT_BITS-1:0];
                        state_reg            <= S_B_SEL;
                        if (f_reg == 3'(NFEAT - 1))
                        begin
                            f_reg <= '0;
                            j_reg <= j_reg + CL_W'(1);
                        end
                        else
                        begin
                            f_reg <= f_reg + 3'd1;
                        end
                    end
                end
                S_CHECK:
                begin
                    err_cur_reg <= err_acc_reg;
                    pass_reg    <= pass_next;
                    j_reg       <= '0;
                    state_reg   <= go_on ? S_PASS : S_OUT;
                end
                S_OUT:
                begin
                    result_valid      <= 1'b1;
                    cluster_index     <= j_reg;
                    mean_two_points   <= cen_reg[j_reg][0];
                    mean_three_points <= cen_reg[j_reg][1];
                    mean_assists      <= cen_reg[j_reg][2];
                    mean_blocks       <= cen_reg[j_reg][3];
                    mean_fouls        <= cen_reg[j_reg][4];
                    member_count      <= cnt_reg[j_reg];
                    total_error       <= err_cur_reg;
                    passes_run        <= pass_reg;
                    if (j_reg == k_reg - CL_W'(1))
                    begin
                        last      <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        j_reg <= j_reg + CL_W'(1);
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `KCE_ASSERT_NEXT(a_results_run, result_valid && !last, result_valid, "result burst broken")
    `KCE_ASSERT_SAME(a_index_in_k, result_valid, cluster_index < k_reg, "result index beyond k")
    `KCE_ASSERT_NEXT(a_run_busy, accept && mode == MODE_RUN, busy, "run did not raise busy")
    `KCE_ASSERT_SAME(a_div_only_wait, drsp.done, state_reg == S_B_DIV && div_wait_reg,
                     "quotient arrived outside divide wait")
endmodule
`default_nettype wire

// ===== hw/rtl/kce_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module kce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/kce_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module kce_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire kce_pkg::div_req_t req,
    output kce_pkg::div_rsp_t   rsp
);
    import kce_pkg::*;

    localparam int CW = $clog2(SUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W:0]   trial;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]};
        ge        = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (trial - {1'b0, dsr_reg}) : trial;
            dvd_next = {dvd_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;
endmodule
`default_nettype wire
